### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the coordinate expander.
// No dependencies; files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SBCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SBCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sbce_pkg.sv
// Shared types and constants for the sparse block to coordinate expander.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package sbce_pkg;

  localparam int unsigned BlockRowW  = 24;
  localparam int unsigned ColStartW  = 27;
  localparam int unsigned BlockNumW  = 24;
  localparam int unsigned OutRowW    = 28;
  localparam int unsigned OutColW    = 28;
  localparam int unsigned ValueIdxW  = 30;
  localparam int unsigned RowBaseW   = 27;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 4;
  localparam int unsigned DimCfgW    = 4;

  // Coordinates are reported one-based.
  localparam logic [OutRowW-1:0] OutputIndexBase = OutRowW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlockHeight    = 2'd0,
    CfgBlockWidth     = 2'd1,
    CfgColumnOriented = 2'd2,
    CfgValueKind      = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KindReal    = 2'd0,
    KindComplex = 2'd1,
    KindPattern = 2'd2,
    KindUnknown = 2'd3
  } value_kind_e;

  // Controller -> datapath
  typedef struct packed {
    logic capture;    // latch request fields, row base and block size
    logic calc_base;  // value base = block number * block size
    logic load_elem;  // present next element, advance counters
  } sbce_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic kind_unknown;  // value kind 3: request yields nothing
    logic elem_last;     // presented element is the block's last
  } sbce_status_t;

endpackage

`default_nettype wire

### hw/rtl/sbce_ctrl.sv
// Sequencer for the coordinate expander: request intake, setup, element emission.
// Depends on sbce_pkg for the command and status structs.
`default_nettype none

module sbce_ctrl
  import sbce_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire sbce_status_t status_i,
  output sbce_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StLoad,
    StEmit
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_take;
  logic   out_take;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign in_take     = in_valid_i && in_ready_o;
  assign out_take    = out_valid_q && out_ready_i;

  always_comb begin
    cmd_o.capture   = in_take && !status_i.kind_unknown;
    cmd_o.calc_base = (state_q == StMul);
    cmd_o.load_elem = (state_q == StLoad) ||
                      ((state_q == StEmit) && out_take && !status_i.elem_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_take && !status_i.kind_unknown) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StLoad;
        end
        StLoad: begin
          state_q     <= StEmit;
          out_valid_q <= 1'b1;
        end
        StEmit: begin
          if (out_take && status_i.elem_last) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q     <= StIdle;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sbce_datapath.sv
// Datapath of the coordinate expander: configuration registers, base multipliers,
// element counters and the output payload register. Depends on sbce_pkg.
`default_nettype none

module sbce_datapath
  import sbce_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_DIM = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  input  wire logic [BlockRowW-1:0] block_row_i,
  input  wire logic [ColStartW-1:0] col_start_i,
  input  wire logic [BlockNumW-1:0] block_number_i,
  input  wire sbce_cmd_t            cmd_i,
  output sbce_status_t              status_o,
  output logic [OutRowW-1:0]        out_row_o,
  output logic [OutColW-1:0]        out_col_o,
  output logic [ValueIdxW-1:0]      value_index_o,
  output logic                      has_value_o,
  output logic                      last_o
);

  localparam int unsigned DimW  = (MAX_BLOCK_DIM > 1) ? $clog2(MAX_BLOCK_DIM) : 1;
  localparam int unsigned DimCW = $clog2(MAX_BLOCK_DIM + 1);
  localparam int unsigned SizeW = 2 * DimCW;
  localparam int unsigned KW    = (MAX_BLOCK_DIM > 1) ? $clog2(MAX_BLOCK_DIM * MAX_BLOCK_DIM) : 1;
  localparam logic [DimCfgW:0] MaxDimX = (DimCfgW + 1)'(MAX_BLOCK_DIM);

  // configuration
  logic [DimCfgW-1:0] height_q;
  logic [DimCfgW-1:0] width_q;
  logic               col_major_q;
  value_kind_e        kind_q;

  // per-block setup
  logic [RowBaseW-1:0]  row_base_q;
  logic [ColStartW-1:0] col_base_q;
  logic [BlockNumW-1:0] block_num_q;
  logic [SizeW-1:0]     size_q;
  logic [ValueIdxW-1:0] value_base_q;

  // element walk
  logic [DimW-1:0] dr_q;
  logic [DimW-1:0] dc_q;
  logic [KW-1:0]   k_q;

  // payload
  logic [OutRowW-1:0]   row_q;
  logic [OutColW-1:0]   col_q;
  logic [ValueIdxW-1:0] vidx_q;
  logic                 hv_q;
  logic                 last_q;

  logic [DimCW-1:0] r_dim;
  logic [DimCW-1:0] c_dim;
  logic             dr_end;
  logic             dc_end;

  // zero reads as one, oversize saturates
  always_comb begin
    if (height_q == '0) begin
      r_dim = DimCW'(1);
    end else if ({1'b0, height_q} > MaxDimX) begin
      r_dim = DimCW'(MAX_BLOCK_DIM);
    end else begin
      r_dim = DimCW'(height_q);
    end
    if (width_q == '0) begin
      c_dim = DimCW'(1);
    end else if ({1'b0, width_q} > MaxDimX) begin
      c_dim = DimCW'(MAX_BLOCK_DIM);
    end else begin
      c_dim = DimCW'(width_q);
    end
  end

  assign dr_end = (DimCW'(dr_q) == r_dim - DimCW'(1));
  assign dc_end = (DimCW'(dc_q) == c_dim - DimCW'(1));

  assign status_o.kind_unknown = (kind_q == KindUnknown);
  assign status_o.elem_last    = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= DimCfgW'(1);
      width_q     <= DimCfgW'(1);
      col_major_q <= 1'b0;
      kind_q      <= KindReal;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgBlockHeight:    height_q    <= cfg_data_i;
        CfgBlockWidth:     width_q     <= cfg_data_i;
        CfgColumnOriented: col_major_q <= cfg_data_i[0];
        CfgValueKind:      kind_q      <= value_kind_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_base_q  <= RowBaseW'(block_row_i) * RowBaseW'(r_dim);
      col_base_q  <= col_start_i;
      block_num_q <= block_number_i;
      size_q      <= SizeW'(r_dim) * SizeW'(c_dim);
      dr_q        <= '0;
      dc_q        <= '0;
      k_q         <= '0;
    end
    if (cmd_i.calc_base) begin
      value_base_q <= ValueIdxW'(block_num_q) * ValueIdxW'(size_q);
    end
    if (cmd_i.load_elem) begin
      row_q  <= OutputIndexBase + OutRowW'(row_base_q) + OutRowW'(dr_q);
      col_q  <= OutputIndexBase + OutColW'(col_base_q) + OutColW'(dc_q);
      vidx_q <= value_base_q + ValueIdxW'(k_q);
      hv_q   <= (kind_q != KindPattern);
      last_q <= dr_end && dc_end;
      k_q    <= k_q + KW'(1);
      if (col_major_q) begin
        if (dr_end) begin
          dr_q <= '0;
          dc_q <= dc_q + DimW'(1);
        end else begin
          dr_q <= dr_q + DimW'(1);
        end
      end else begin
        if (dc_end) begin
          dc_q <= '0;
          dr_q <= dr_q + DimW'(1);
        end else begin
          dc_q <= dc_q + DimW'(1);
        end
      end
    end
  end

  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign value_index_o = vidx_q;
  assign has_value_o   = hv_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

### hw/rtl/sparse_block_to_coordinate_expander_top.sv
// Top level of the sparse block to coordinate expander: controller plus datapath.
// Depends on sbce_pkg, sbce_ctrl, sbce_datapath and assert_macros.svh.
//
// Each input request names one nonzero block of a block-compressed sparse row
// matrix (block row, zero-based left column, block number). The block answers
// with r*c coordinate results, one per element, in row-major order, or in
// column-major order when column_oriented is set. A result carries the one-based
// row (1 + block_row*r + row in block) and column (1 + col_start + column in
// block), the value index (block_number*r*c + element offset), has_value (clear
// for pattern matrices) and last on the final element. Sums wrap to the port
// widths. Height and width of 0 count as 1 and values above MAX_BLOCK_DIM
// saturate. With value_kind 3 a request is taken and yields no result.
// Timing: one request at a time. After acceptance the block latches the fields
// with block_row*r and r*c, then forms block_number*(r*c), then loads the first
// element, then emits one element per cycle from the element counters while
// out_ready_i is high; in_ready_o rises again once the last element is taken.
// A value_kind 3 request leaves the block idle and ready.
// Configuration writes are taken every cycle (cfg_ready_o is tied high) and must
// only be issued while no block is in flight.
`default_nettype none

module sparse_block_to_coordinate_expander_top
  import sbce_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_DIM = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // block request channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [BlockRowW-1:0] block_row_i,
  input  wire logic [ColStartW-1:0] col_start_i,
  input  wire logic [BlockNumW-1:0] block_number_i,
  // coordinate result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [OutRowW-1:0]        out_row_o,
  output logic [OutColW-1:0]        out_col_o,
  output logic [ValueIdxW-1:0]      value_index_o,
  output logic                      has_value_o,
  output logic                      last_o
);

`include "assert_macros.svh"

  sbce_cmd_t    cmd;
  sbce_status_t status;

  // config registers never back-pressure
  assign cfg_ready_o = 1'b1;

  sbce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sbce_datapath #(
    .MAX_BLOCK_DIM (MAX_BLOCK_DIM)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .block_row_i    (block_row_i),
    .col_start_i    (col_start_i),
    .block_number_i (block_number_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .value_index_o  (value_index_o),
    .has_value_o    (has_value_o),
    .last_o         (last_o)
  );

  // Results and request intake never overlap.
  `SBCE_ASSERT_NOW(a_no_intake_while_emitting, out_valid_o, !in_ready_o, "intake during emission")
  // A freshly taken request needs setup before its first result.
  `SBCE_ASSERT_NEXT(a_setup_before_result, in_valid_i && in_ready_o, !out_valid_o, "result without setup")
  // Within a block, results follow back to back until last.
  `SBCE_ASSERT_NEXT(a_block_continues, out_valid_o && out_ready_i && !last_o, out_valid_o, "block cut short")
  // The last element closes the block.
  `SBCE_ASSERT_NEXT(a_last_closes, out_valid_o && out_ready_i && last_o, !out_valid_o && in_ready_o, "emission past last")

endmodule

`default_nettype wire

### verif/tb_sparse_block_to_coordinate_expander_top.sv
// Self-checking testbench for sparse_block_to_coordinate_expander_top.
// Depends on sbce_pkg and the expander RTL; predicts each coordinate in-line,
// drives block requests and config writes, and scores the result stream.
`timescale 1ns / 1ps

module tb_sparse_block_to_coordinate_expander_top;
  import sbce_pkg::*;

  localparam int unsigned MaxDim      = 8;
  localparam int unsigned SettleCyc   = 12;       // settle time after the last coordinate
  localparam int unsigned TailCyc     = 80;       // quiet window after the last result
  localparam int unsigned MaxReport   = 10;       // mismatches printed in full
  localparam int unsigned RandomReqs  = 80;
  localparam int unsigned MaxBatch    = 14;       // requests per random phase, at most
  localparam longint      TimeoutNs   = 20_000_000;

  // One block request as the driver presents it. hold_for_drain makes the
  // driver sit on the request until every predicted coordinate has come back.
  typedef struct {
    logic [BlockRowW-1:0] brow;
    logic [ColStartW-1:0] cst;
    logic [BlockNumW-1:0] bnum;
    bit                   hold_for_drain;
  } block_req_t;

  // One predicted coordinate result.
  typedef struct packed {
    logic [OutRowW-1:0]   row;
    logic [OutColW-1:0]   col;
    logic [ValueIdxW-1:0] vidx;
    logic                 has_val;
    logic                 last;
  } coord_t;

  // Clock, reset and every block input start at known values.
  logic                 clk_i        = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index    = '0;
  logic [CfgDataW-1:0]  cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic [BlockRowW-1:0] block_row    = '0;
  logic [ColStartW-1:0] col_start    = '0;
  logic [BlockNumW-1:0] block_number = '0;
  logic                 out_ready    = 1'b0;

  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [OutRowW-1:0]   out_row_o;
  logic [OutColW-1:0]   out_col_o;
  logic [ValueIdxW-1:0] value_index_o;
  logic                 has_value_o;
  logic                 last_o;

  // Shadow of the configuration registers, reset values first.
  logic [DimCfgW-1:0] height_cfg   = 4'd1;
  logic [DimCfgW-1:0] width_cfg    = 4'd1;
  logic               colmajor_cfg = 1'b0;
  logic [1:0]         kind_cfg     = KindReal;

  block_req_t  block_queue[$];     // requests waiting for the driver
  coord_t      pending_coords[$];  // predicted coordinates, oldest first

  int unsigned blocks_queued  = 0;
  int unsigned blocks_taken   = 0;
  int unsigned coords_checked = 0;
  int unsigned settings_used  = 0;
  int unsigned errors         = 0;
  bit          calm_tail      = 1'b0;  // no idling on either side

  int          send_gap  = 0;
  int          stall_left = 0;
  bit          next_valid;
  block_req_t  next_req;
  bit          next_ready;
  coord_t      want;
  coord_t      got;

  sparse_block_to_coordinate_expander_top #(
    .MAX_BLOCK_DIM(MaxDim)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .block_row_i   (block_row),
    .col_start_i   (col_start),
    .block_number_i(block_number),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .value_index_o (value_index_o),
    .has_value_o   (has_value_o),
    .last_o        (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Zero and oversize dimensions saturate into 1..MaxDim.
  function automatic int unsigned eff_dim(input logic [DimCfgW-1:0] d);
    if (d == '0) return 1;
    if (d > MaxDim) return MaxDim;
    return 32'(d);
  endfunction

  // Expand one accepted block request into its r*c coordinates, in storage
  // order, and queue them. Unknown value kind yields nothing.
  function automatic void expand_block(input logic [BlockRowW-1:0] brow,
                                       input logic [ColStartW-1:0] cst,
                                       input logic [BlockNumW-1:0] bnum);
    int unsigned          r;
    int unsigned          c;
    int unsigned          sz;
    int unsigned          k;
    int unsigned          dr;
    int unsigned          dc;
    logic [RowBaseW-1:0]  row_base;
    logic [ValueIdxW-1:0] val_base;
    coord_t               e;
    if (kind_cfg == KindUnknown) return;
    r  = eff_dim(height_cfg);
    c  = eff_dim(width_cfg);
    sz = r * c;
    // Bases are truncated to their register widths before the per-element add.
    row_base = RowBaseW'(64'(brow) * r);
    val_base = ValueIdxW'(64'(bnum) * sz);
    for (k = 0; k < sz; k++) begin
      if (colmajor_cfg) begin
        dr = k % r;
        dc = k / r;
      end else begin
        dr = k / c;
        dc = k % c;
      end
      e.row     = OutRowW'(64'(OutputIndexBase) + row_base + dr);
      e.col     = OutColW'(64'(OutputIndexBase) + cst + dc);
      e.vidx    = ValueIdxW'(64'(val_base) + k);
      e.has_val = (kind_cfg != KindPattern);
      e.last    = (k == sz - 1);
      pending_coords.push_back(e);
    end
  endfunction

  // Request driver: presents queued blocks, predicts on acceptance, and
  // inserts random idle bursts between requests.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      block_row    <= '0;
      col_start    <= '0;
      block_number <= '0;
      send_gap     = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        expand_block(block_row, col_start, block_number);
        blocks_taken++;
      end
      if (calm_tail) send_gap = 0;
      // Valid may only change once the current request is gone.
      if (!in_valid || in_ready_o) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (block_queue.size() > 0 &&
                     (!block_queue[0].hold_for_drain || pending_coords.size() == 0)) begin
          if (!calm_tail && $urandom_range(0, 5) == 0) begin
            // valid stays low while send_gap counts down
            send_gap = $urandom_range(0, 18);
          end else begin
            next_req     = block_queue.pop_front();
            next_valid   = 1'b1;
            block_row    <= next_req.brow;
            col_start    <= next_req.cst;
            block_number <= next_req.bnum;
          end
        end
        in_valid <= next_valid;
      end
    end
  end

  // Result monitor: compares each accepted coordinate with the oldest
  // prediction and stalls the output side in random bursts.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        got = '{out_row_o, out_col_o, value_index_o, has_value_o, last_o};
        if (pending_coords.size() == 0) begin
          errors++;
          if (errors <= MaxReport)
            $display("unexpected coordinate: row %0d col %0d vidx %0d hv %0b last %0b",
                     got.row, got.col, got.vidx, got.has_val, got.last);
        end else begin
          want = pending_coords.pop_front();
          coords_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= MaxReport) begin
              $display("coordinate mismatch: exp row %0d col %0d vidx %0d hv %0b last %0b",
                       want.row, want.col, want.vidx, want.has_val, want.last);
              $display("                     got row %0d col %0d vidx %0d hv %0b last %0b",
                       got.row, got.col, got.vidx, got.has_val, got.last);
            end
          end
        end
      end
      next_ready = 1'b1;
      if (calm_tail) begin
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  // Write all four registers back to back; only called with the block idle.
  // Unused upper data bits of the one- and two-bit registers carry noise.
  task automatic apply_settings(input logic [DimCfgW-1:0] h, input logic [DimCfgW-1:0] w,
                                input logic co, input logic [1:0] vk);
    int                  i;
    cfg_reg_e            idx;
    logic [CfgDataW-1:0] val;
    for (i = 0; i < 4; i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        CfgBlockHeight:    val = h;
        CfgBlockWidth:     val = w;
        CfgColumnOriented: val = {3'($urandom), co};
        default:           val = {2'($urandom), vk};
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx)
        CfgBlockHeight:    height_cfg   = val;
        CfgBlockWidth:     width_cfg    = val;
        CfgColumnOriented: colmajor_cfg = val[0];
        default:           kind_cfg     = val[1:0];
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_block(input logic [BlockRowW-1:0] brow, input logic [ColStartW-1:0] cst,
                             input logic [BlockNumW-1:0] bnum, input bit hold = 1'b0);
    block_queue.push_back('{brow, cst, bnum, hold});
    blocks_queued++;
  endtask

  // Wait until every request is taken and every coordinate is back, then let
  // the block finish any request that produced nothing.
  task automatic drain_block();
    while (blocks_taken != blocks_queued || pending_coords.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Field value biased toward the extremes.
  function automatic logic [31:0] pick_field(input int unsigned width);
    logic [31:0] mask;
    mask = (32'd1 << width) - 1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return mask;
      2:       return mask - $urandom_range(0, 70);
      default: return $urandom() & mask;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned          n;
    int unsigned          j;
    int unsigned          random_sent;
    logic [DimCfgW-1:0]   h;
    logic [DimCfgW-1:0]   w;
    logic [1:0]           vk;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset settings first: 1x1, row-major, real.
    queue_block('0, '0, '0);
    queue_block('1, '1, '1);  // all-ones fields, largest operands
    queue_block(24'h555555, 27'h5555555, 24'hAAAAAA);
    drain_block();

    // Common 2x2 case; second request waits for a fully drained pipe.
    apply_settings(4'd2, 4'd2, 1'b0, KindReal);
    queue_block(24'd1, 27'd2, 24'd3);
    queue_block(24'hAAAAAA, 27'h2AAAAAA, 24'h555555, 1'b1);
    queue_block('1, '1, '1);
    drain_block();

    // Largest block, column-major, complex values.
    apply_settings(4'd8, 4'd8, 1'b1, KindComplex);
    queue_block('0, '0, '0);
    queue_block('1, '1, '1);
    drain_block();

    // Zero height counts as one, oversize width saturates; pattern matrix.
    apply_settings(4'd0, 4'd15, 1'b0, KindPattern);
    queue_block(24'd5, 27'd7, 24'd9);
    queue_block('1, 27'h7FFFFF0, '1);
    drain_block();

    // Oversize height, zero width, column-major pattern.
    apply_settings(4'd15, 4'd0, 1'b1, KindPattern);
    queue_block(24'd3, 27'd100, 24'd11);
    queue_block('1, '1, 24'h800000);
    drain_block();

    // Non-square block shows the layout order.
    apply_settings(4'd3, 4'd5, 1'b1, KindReal);
    queue_block(24'd7, 27'd20, 24'd2);
    queue_block(24'h123456, 27'h4000000, 24'h0FFFFF);
    drain_block();

    // Unknown value kind: requests are taken and produce nothing.
    apply_settings(4'd2, 4'd3, 1'b0, KindUnknown);
    queue_block(24'd1, 27'd1, 24'd1);
    queue_block('1, '1, '1);
    drain_block();

    // Back to a normal kind after the silent requests.
    apply_settings(4'd1, 4'd1, 1'b0, KindReal);
    queue_block(24'd42, 27'd43, 24'd44);
    drain_block();

    // Random phases: small blocks mostly, the full register range now and then.
    random_sent = 0;
    while (random_sent < RandomReqs) begin
      h  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
      w  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 4));
      vk = ($urandom_range(0, 9) == 0) ? 2'(KindUnknown) : 2'($urandom_range(0, 2));
      // Final stretch runs with no idling and a plain kind.
      if (random_sent + MaxBatch >= RandomReqs) begin
        calm_tail = 1'b1;
        vk = 2'($urandom_range(0, 2));
      end
      apply_settings(h, w, 1'($urandom_range(0, 1)), vk);
      n = $urandom_range(6, MaxBatch);
      for (j = 0; j < n; j++)
        queue_block(BlockRowW'(pick_field(BlockRowW)), ColStartW'(pick_field(ColStartW)),
                    BlockNumW'(pick_field(BlockNumW)), $urandom_range(0, 14) == 0);
      random_sent += n;
      drain_block();
    end

    repeat (TailCyc) @(posedge clk_i);

    $display("Covered %0d block requests under %0d register settings, %0d coordinates checked.",
             blocks_taken, settings_used, coords_checked);
    $display("Mismatched or unexpected coordinates: %0d.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing coordinate ends here.
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d coordinates still outstanding.", pending_coords.size());
    $display("FAIL");
    $finish;
  end

endmodule
